>>> rtl/eihp_pkg.sv
// ----------------------------------------------------------------------------
// eihp_pkg
// Shared types and constants for the Ethernet/IP/L4 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package eihp_pkg;

    // Default limit of the byte counter and depth of the summary queue.
    localparam int DEF_MAX_FRAME_BYTES = 16383;
    localparam int DEF_QUEUE_DEPTH     = 4;

    // Fixed output widths.
    localparam int SIZE_W     = 14;
    localparam int SIZE_MAX   = 16383;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 4;

    // Ethertypes.
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [15:0] ETH_ARP  = 16'h0806;

    // IP protocol numbers.
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    // Packet class codes.
    localparam logic [2:0] CLS_UNKNOWN = 3'd0;
    localparam logic [2:0] CLS_IPV4    = 3'd1;
    localparam logic [2:0] CLS_IPV6    = 3'd2;
    localparam logic [2:0] CLS_ARP     = 3'd3;
    localparam logic [2:0] CLS_ICMPV6  = 3'd4;

    // Network layer codes.
    localparam logic [1:0] NET_NONE = 2'd0;
    localparam logic [1:0] NET_IPV4 = 2'd1;
    localparam logic [1:0] NET_IPV6 = 2'd2;

    // Transport layer codes.
    localparam logic [1:0] TRN_NONE = 2'd0;
    localparam logic [1:0] TRN_TCP  = 2'd1;
    localparam logic [1:0] TRN_UDP  = 2'd2;

    // Header fields captured from one frame.
    typedef struct packed {
        logic [15:0] ethertype;
        logic [7:0]  ver_len;
        logic [7:0]  protocol;
        logic [31:0] ports;        // source port in the upper half
        logic [15:0] tcp_off_flags; // data offset byte high, flags byte low
    } t_hdr_fields;

endpackage

`default_nettype wire

>>> rtl/eihp_front.sv
// ----------------------------------------------------------------------------
// eihp_front
// Byte counter and fixed-offset field capture; pushes one record per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module eihp_front
    import eihp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int CW              = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_data,
    input  wire logic          i_last,
    output logic               o_push,
    output logic [CW-1:0]      o_count,
    output t_hdr_fields        o_fields
);

    localparam int OFFW = 7;

    logic [CW-1:0] r_byte_index, n_byte_index;
    t_hdr_fields   r_cap, n_cap, cap;
    logic [OFFW-1:0] toff;
    logic            toff_ok;
    logic [CW-1:0]   pos;
    logic [CW-1:0]   cnt_inc;

    always_comb begin
        pos     = r_byte_index;
        cap     = r_cap;
        toff_ok = (r_cap.ethertype == ETH_IPV4) || (r_cap.ethertype == ETH_IPV6);
        if (r_cap.ethertype == ETH_IPV4) begin
            toff = OFFW'(14) + {1'b0, r_cap.ver_len[3:0], 2'b00};
        end else begin
            toff = OFFW'(54);
        end

        if (pos == CW'(12)) begin
            cap.ethertype = {i_data, 8'h00};
        end else if (pos == CW'(13)) begin
            cap.ethertype = {r_cap.ethertype[15:8], i_data};
        end else if (pos == CW'(14)) begin
            cap.ver_len = i_data;
        end

        if ((r_cap.ethertype == ETH_IPV4 && pos == CW'(23)) ||
            (r_cap.ethertype == ETH_IPV6 && pos == CW'(20))) begin
            cap.protocol = i_data;
        end

        if (pos >= CW'(15) && toff_ok) begin
            if (pos >= CW'(toff) && pos < CW'(toff + OFFW'(4))) begin
                cap.ports = {r_cap.ports[23:0], i_data};
            end else if (pos == CW'(toff + OFFW'(12))) begin
                cap.tcp_off_flags = {i_data, r_cap.tcp_off_flags[7:0]};
            end else if (pos == CW'(toff + OFFW'(13))) begin
                cap.tcp_off_flags = {r_cap.tcp_off_flags[15:8], i_data};
            end
        end

        if (r_byte_index < CW'(MAX_FRAME_BYTES)) begin
            cnt_inc = r_byte_index + CW'(1);
        end else begin
            cnt_inc = r_byte_index;
        end

        n_cap        = r_cap;
        n_byte_index = r_byte_index;
        if (i_accept) begin
            if (i_last) begin
                n_cap        = '0;
                n_byte_index = '0;
            end else begin
                n_cap        = cap;
                n_byte_index = cnt_inc;
            end
        end
    end

    assign o_push   = i_accept && i_last;
    assign o_count  = cnt_inc;
    assign o_fields = cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_cap        <= '0;
        end else begin
            r_byte_index <= n_byte_index;
            r_cap        <= n_cap;
        end
    end

endmodule

`default_nettype wire

>>> rtl/eihp_queue.sv
// ----------------------------------------------------------------------------
// eihp_queue
// Small register queue of per-frame records between capture and decode.
// ----------------------------------------------------------------------------
`default_nettype none

module eihp_queue
    import eihp_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH,
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + NW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // A push into a full queue would drop a frame summary.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("summary queue overflow");

    // Occupancy moves by the net of push and pop.
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + NW'(1))
        else $error("queue count did not follow a push");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> rtl/eihp_back.sv
// ----------------------------------------------------------------------------
// eihp_back
// Decodes one captured frame record into the summary and holds it for output.
// ----------------------------------------------------------------------------
`default_nettype none

module eihp_back
    import eihp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int CW              = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [CW-1:0]         i_count,
    input  wire t_hdr_fields           i_fields,
    output logic                       o_pop,
    output logic                       o_tvalid,
    input  wire logic                  i_tready,
    output logic [OUT_DATA_W-1:0]      o_tdata,
    output logic [OUT_USER_W-1:0]      o_tuser
);

    localparam int AW = ((CW > SIZE_W) ? CW : SIZE_W) + 1;

    logic [AW-1:0] total, ip_end, hdr, diff;
    logic [3:0]    ver, ihl, doff;
    logic [2:0]    cls;
    logic [1:0]    net, trn;
    logic [7:0]    proto, flags;
    logic [15:0]   sport, dport;
    logic          malformed;

    logic             r_valid;
    logic             r_malformed;
    logic [2:0]       r_cls;
    logic [15:0]      r_ethertype;
    logic [1:0]       r_net, r_trn;
    logic [7:0]       r_proto, r_flags;
    logic [15:0]      r_sport, r_dport;
    logic [SIZE_W-1:0] r_hdr_bytes, r_pay_bytes, r_frame_bytes;
    logic [SIZE_W-1:0] hdr_bytes, pay_bytes, frame_bytes;
    logic [15:0]      ethertype;

    always_comb begin
        total     = AW'(i_count);
        ver       = i_fields.ver_len[7:4];
        ihl       = i_fields.ver_len[3:0];
        doff      = i_fields.tcp_off_flags[15:12];
        malformed = (total < AW'(14));
        cls       = CLS_UNKNOWN;
        net       = NET_NONE;
        trn       = TRN_NONE;
        proto     = '0;
        flags     = '0;
        sport     = '0;
        dport     = '0;
        hdr       = AW'(14);
        ip_end    = '0;

        if (i_fields.ethertype == ETH_IPV4) begin
            cls = CLS_IPV4;
        end else if (i_fields.ethertype == ETH_IPV6) begin
            cls = CLS_IPV6;
        end else if (i_fields.ethertype == ETH_ARP) begin
            cls = CLS_ARP;
        end

        if (cls == CLS_IPV4 && total >= AW'(34) && ver == 4'd4 && ihl >= 4'd5) begin
            net    = NET_IPV4;
            ip_end = AW'(14) + AW'({ihl, 2'b00});
        end else if (cls == CLS_IPV6 && total >= AW'(54) && ver == 4'd6) begin
            net    = NET_IPV6;
            ip_end = AW'(54);
        end

        if (net != NET_NONE) begin
            proto = i_fields.protocol;
            hdr   = ip_end;
            if (ip_end < total) begin
                if (proto == PROTO_TCP && ip_end + AW'(20) <= total) begin
                    trn   = TRN_TCP;
                    flags = i_fields.tcp_off_flags[7:0];
                    hdr   = ip_end + AW'({doff, 2'b00});
                end else if (proto == PROTO_UDP && ip_end + AW'(8) <= total) begin
                    trn = TRN_UDP;
                    hdr = ip_end + AW'(8);
                end else if (net == NET_IPV6 && proto == PROTO_ICMPV6) begin
                    cls = CLS_ICMPV6;
                end
            end
            if (trn != TRN_NONE) begin
                sport = i_fields.ports[31:16];
                dport = i_fields.ports[15:0];
            end
        end

        diff        = (total > hdr) ? total - hdr : '0;
        hdr_bytes   = (hdr > AW'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX) : hdr[SIZE_W-1:0];
        pay_bytes   = (diff > AW'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX) : diff[SIZE_W-1:0];
        frame_bytes = (total > AW'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX) : total[SIZE_W-1:0];
        ethertype   = i_fields.ethertype;

        // A short frame reports only the malformed flag.
        if (malformed) begin
            cls         = CLS_UNKNOWN;
            ethertype   = '0;
            net         = NET_NONE;
            trn         = TRN_NONE;
            proto       = '0;
            sport       = '0;
            dport       = '0;
            flags       = '0;
            hdr_bytes   = '0;
            pay_bytes   = '0;
            frame_bytes = '0;
        end
    end

    assign o_pop = i_valid && (!r_valid || i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_malformed   <= malformed;
            r_cls         <= cls;
            r_ethertype   <= ethertype;
            r_net         <= net;
            r_trn         <= trn;
            r_proto       <= proto;
            r_sport       <= sport;
            r_dport       <= dport;
            r_flags       <= flags;
            r_hdr_bytes   <= hdr_bytes;
            r_pay_bytes   <= pay_bytes;
            r_frame_bytes <= frame_bytes;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = {r_cls, r_malformed};
    assign o_tdata  = {2'b00, r_frame_bytes, r_pay_bytes, r_hdr_bytes, r_flags,
                       r_dport, r_sport, r_proto, r_trn, r_net, r_ethertype};

    // A malformed summary carries no decoded content.
    a_malformed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_malformed) |-> (r_frame_bytes == '0 && r_net == NET_NONE &&
                                      r_cls == CLS_UNKNOWN))
        else $error("malformed summary with decoded fields");

    // Transport decode needs a valid network header underneath.
    a_trn_needs_net: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_trn != TRN_NONE) |-> r_net != NET_NONE)
        else $error("transport decoded without network layer");

    // Flags are only reported for TCP.
    a_flags_tcp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_flags != '0) |-> r_trn == TRN_TCP)
        else $error("tcp flags reported for a non-tcp frame");

endmodule

`default_nettype wire

>>> rtl/eth_ip_l4_header_parser_unit.sv
// The last byte's record is queued, then decoded into the output register for the master side.
// Throughput: one byte per cycle sustained; frames may follow each other back to back.
// The slave side stalls only while the four-entry queue of pending frame summaries is full.
// Reset: synchronous, active low; clears the byte counter, captured fields, queue and output valid.
// ----------------------------------------------------------------------------
// eth_ip_l4_header_parser_unit
// Byte-stream Ethernet/IPv4/IPv6/TCP/UDP header parser with one summary per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module eth_ip_l4_header_parser_unit
    import eihp_pkg::*;
#(
    // Saturation limit of the frame byte counter (64 to 65535).
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    // Number of frame summaries that may wait between capture and decode.
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Slave side: one frame byte per transfer.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] data_byte
    input  wire logic                  s_axis_tlast,  // last_byte
    // Master side: one summary per frame.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [15:0] ethertype, [17:16] network_layer, [19:18] transport_layer,
    // [27:20] ip_protocol, [43:28] source_port, [59:44] destination_port,
    // [67:60] tcp_flag_bits, [81:68] header_bytes, [95:82] payload_bytes,
    // [109:96] frame_bytes, [111:110] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] malformed, [3:1] packet_class
    output logic [OUT_USER_W-1:0]      m_axis_tuser
);

    // The front counts bytes and captures header fields at fixed offsets as
    // they stream by. On the last byte it pushes the captured record and the
    // saturated byte count into a short queue. The back pops records, decodes
    // the protocol layers and sizes, and holds the summary in an output
    // register until the downstream side takes it. The queue lets the byte
    // stream keep flowing while a summary waits on a stalled master side.

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int RW = CW + $bits(t_hdr_fields);

    logic            accept;
    logic            push;
    logic [CW-1:0]   front_count;
    t_hdr_fields     front_fields;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic [RW-1:0]   q_rd_data;
    logic [CW-1:0]   back_count;
    t_hdr_fields     back_fields;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    eihp_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CW              (CW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_count  (front_count),
        .o_fields (front_fields)
    );

    eihp_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (RW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_count, front_fields}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rd_data)
    );

    assign back_count  = q_rd_data[RW-1 -: CW];
    assign back_fields = q_rd_data[$bits(t_hdr_fields)-1:0];

    eihp_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CW              (CW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_count  (back_count),
        .i_fields (back_fields),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for eth_ip_l4_header_parser_unit. Frames are streamed in
// one byte per transfer, and a byte-level model of the parser predicts one
// summary per frame. Each summary that leaves the master side is compared
// field by field with the oldest prediction. Directed frames cover short,
// IPv4, IPv6, ARP and unknown frames. Random traffic follows, with random
// idle bursts on both sides and a final stretch without them.
// ----------------------------------------------------------------------------
module testbench;
    import eihp_pkg::*;

    // Fixed offsets and sizes of the header layout.
    localparam int ETH_HDR_BYTES = 14;
    localparam int IPV4_MIN_END  = 34;
    localparam int IPV6_END      = 54;
    localparam int TCP_MIN_BYTES = 20;
    localparam int UDP_HDR_BYTES = 8;
    localparam int IPV4_PROTO_AT = 23;
    localparam int IPV6_NEXT_AT  = 20;

    // Random traffic runs until both of these are reached.
    localparam int RANDOM_BYTES  = 100;
    localparam int RANDOM_FRAMES = 2;

    // Idle cycles added after the last predicted summary has arrived.
    localparam int DRAIN_CYCLES  = 6;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;

    // Running capture state of the frame being received.
    typedef struct packed {
        logic [13:0] pos;
        logic [15:0] etype;
        logic [7:0]  verlen;
        logic [7:0]  proto;
        logic [31:0] ports;
        logic [15:0] offflags;
    } t_parse_state;

    // One frame summary, as carried by tuser and tdata.
    typedef struct packed {
        logic        malformed;
        logic [2:0]  pclass;
        logic [15:0] etype;
        logic [1:0]  net;
        logic [1:0]  trn;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  flags;
        logic [13:0] hdr;
        logic [13:0] payload;
        logic [13:0] frame;
    } t_summary;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    t_parse_state frame_state;
    t_summary     pending_summaries[$];
    logic [7:0]   frame_buf[$];
    int           mismatches;
    int           idle_cycles;
    bit           steady_flow;

    eth_ip_l4_header_parser_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Decodes the captured fields of a finished frame into its summary.
    task automatic close_frame();
        t_summary   s;
        int         total;
        int         hdr;
        int         ip_end;
        logic [3:0] ver;
        logic [3:0] ihl;
        total  = int'(frame_state.pos);
        hdr    = ETH_HDR_BYTES;
        ip_end = 0;
        ver    = frame_state.verlen[7:4];
        ihl    = frame_state.verlen[3:0];
        s      = '0;
        if (total < ETH_HDR_BYTES) begin
            // A short frame reports only the malformed flag.
            s.malformed = 1'b1;
        end else begin
            if (frame_state.etype == ETH_IPV4) begin
                s.pclass = CLS_IPV4;
            end else if (frame_state.etype == ETH_IPV6) begin
                s.pclass = CLS_IPV6;
            end else if (frame_state.etype == ETH_ARP) begin
                s.pclass = CLS_ARP;
            end else begin
                s.pclass = CLS_UNKNOWN;
            end
            s.etype = frame_state.etype;
            if (s.pclass == CLS_IPV4 && total >= IPV4_MIN_END && ver == 4'd4 && ihl >= 4'd5) begin
                s.net  = NET_IPV4;
                ip_end = ETH_HDR_BYTES + 4 * int'(ihl);
            end else if (s.pclass == CLS_IPV6 && total >= IPV6_END && ver == 4'd6) begin
                s.net  = NET_IPV6;
                ip_end = IPV6_END;
            end
            if (s.net != NET_NONE) begin
                s.proto = frame_state.proto;
                hdr     = ip_end;
                // The transport header needs at least one byte past the IP header
                // and its own minimum size before it is decoded.
                if (ip_end < total) begin
                    if (frame_state.proto == PROTO_TCP && ip_end + TCP_MIN_BYTES <= total) begin
                        s.trn   = TRN_TCP;
                        s.flags = frame_state.offflags[7:0];
                        hdr     = ip_end + 4 * int'(frame_state.offflags[15:12]);
                    end else if (frame_state.proto == PROTO_UDP &&
                                 ip_end + UDP_HDR_BYTES <= total) begin
                        s.trn = TRN_UDP;
                        hdr   = ip_end + UDP_HDR_BYTES;
                    end else if (s.net == NET_IPV6 && frame_state.proto == PROTO_ICMPV6) begin
                        s.pclass = CLS_ICMPV6;
                    end
                end
                if (s.trn != TRN_NONE) begin
                    s.sport = frame_state.ports[31:16];
                    s.dport = frame_state.ports[15:0];
                end
            end
            // The count is already saturated and the header end stays small,
            // so all three sizes fit their fields as they are.
            s.hdr     = 14'(hdr);
            s.payload = (total > hdr) ? 14'(total - hdr) : 14'd0;
            s.frame   = 14'(total);
        end
        pending_summaries = {pending_summaries, s};
    endtask

    // Captures one accepted byte at its position in the frame.
    task automatic capture_byte(input logic [7:0] b, input logic is_last);
        int p;
        int t;
        p = int'(frame_state.pos);
        if (p == 12) begin
            frame_state.etype = {b, 8'h00};
        end else if (p == 13) begin
            frame_state.etype[7:0] = b;
        end else if (p == ETH_HDR_BYTES) begin
            frame_state.verlen = b;
        end
        if ((frame_state.etype == ETH_IPV4 && p == IPV4_PROTO_AT) ||
            (frame_state.etype == ETH_IPV6 && p == IPV6_NEXT_AT)) begin
            frame_state.proto = b;
        end
        if (p > ETH_HDR_BYTES) begin
            // The transport offset follows from the ethertype and the IHL as
            // captured so far, even when they later turn out to be invalid.
            if (frame_state.etype == ETH_IPV4) begin
                t = ETH_HDR_BYTES + 4 * int'(frame_state.verlen[3:0]);
            end else if (frame_state.etype == ETH_IPV6) begin
                t = IPV6_END;
            end else begin
                t = 0;
            end
            if (t != 0) begin
                if (p >= t && p < t + 4) begin
                    frame_state.ports = {frame_state.ports[23:0], b};
                end else if (p == t + 12) begin
                    frame_state.offflags[15:8] = b;
                end else if (p == t + 13) begin
                    frame_state.offflags[7:0] = b;
                end
            end
        end
        if (p < DEF_MAX_FRAME_BYTES) begin
            frame_state.pos = frame_state.pos + 14'd1;
        end
        if (is_last) begin
            close_frame();
            frame_state = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Sends one byte, sometimes after an idle burst, and waits for its transfer.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
            // Junk on the data lines while valid is low must be ignored.
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        capture_byte(b, is_last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    function automatic void place_byte(input int idx, input logic [7:0] v);
        if (idx < frame_buf.size()) frame_buf[idx] = v;
    endfunction

    // Builds a frame of random bytes with the given header fields placed at
    // their offsets; fields beyond the frame end are dropped.
    task automatic fill_frame(input int len, input logic [15:0] etype, input logic [7:0] verlen,
                              input logic [7:0] proto, input logic [7:0] tcp_off,
                              input logic [7:0] tcp_flags);
        int l4;
        frame_buf.delete();
        repeat (len) frame_buf = {frame_buf, 8'($urandom)};
        place_byte(12, etype[15:8]);
        place_byte(13, etype[7:0]);
        place_byte(ETH_HDR_BYTES, verlen);
        if (etype == ETH_IPV4 || etype == ETH_IPV6) begin
            if (etype == ETH_IPV4) begin
                l4 = ETH_HDR_BYTES + 4 * int'(verlen[3:0]);
                place_byte(IPV4_PROTO_AT, proto);
            end else begin
                l4 = IPV6_END;
                place_byte(IPV6_NEXT_AT, proto);
            end
            place_byte(l4 + 12, tcp_off);
            place_byte(l4 + 13, tcp_flags);
        end
    endtask

    // Mostly well-formed IP frames with random content, plus ARP, unknown,
    // noise and truncated frames.
    task automatic build_random_frame();
        int         pick;
        int         ihl;
        int         len;
        logic [15:0] etype;
        logic [7:0]  verlen;
        logic [7:0]  proto;
        logic [7:0]  tcp_off;
        pick = $urandom_range(0, 9);
        ihl  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
        case ($urandom_range(0, 4))
            0:       proto = PROTO_UDP;
            1, 2:    proto = PROTO_TCP;
            3:       proto = PROTO_ICMPV6;
            default: proto = 8'($urandom);
        endcase
        tcp_off = {4'($urandom_range(5, 10)), 4'($urandom)};
        if ($urandom_range(0, 7) == 0) tcp_off = 8'($urandom);
        if (pick <= 3) begin
            etype  = ETH_IPV4;
            verlen = {4'd4, 4'(ihl)};
            len    = ETH_HDR_BYTES + 4 * ihl + $urandom_range(0, 32);
        end else if (pick <= 6) begin
            etype  = ETH_IPV6;
            verlen = {4'd6, 4'($urandom)};
            len    = IPV6_END + $urandom_range(0, 32);
        end else if (pick == 7) begin
            etype  = ($urandom_range(0, 1) == 0) ? ETH_ARP : 16'($urandom);
            verlen = 8'($urandom);
            len    = $urandom_range(ETH_HDR_BYTES, 64);
        end else if (pick == 8) begin
            // Pure noise, often shorter than an Ethernet header.
            etype  = 16'($urandom);
            verlen = 8'($urandom);
            len    = $urandom_range(1, 40);
        end else begin
            // An IP frame cut off somewhere inside its headers.
            etype  = ($urandom_range(0, 1) == 0) ? ETH_IPV4 : ETH_IPV6;
            verlen = (etype == ETH_IPV4) ? {4'd4, 4'(ihl)} : {4'd6, 4'($urandom)};
            len    = $urandom_range(ETH_HDR_BYTES, 70);
        end
        if ($urandom_range(0, 15) == 0) verlen = 8'($urandom);
        fill_frame(len, etype, verlen, proto, tcp_off, 8'($urandom));
    endtask

    // Holds the sender off until every predicted summary has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_short_frames();
        // All-zero and all-one frames give the byte extremes.
        frame_buf.delete();
        repeat (20) frame_buf = {frame_buf, 8'h00};
        send_frame();
        frame_buf.delete();
        repeat (20) frame_buf = {frame_buf, 8'hFF};
        send_frame();
        // A single byte, one byte short of a header, and exactly a header.
        fill_frame(1, ETH_IPV4, 8'h45, PROTO_TCP, 8'h50, 8'h12);
        send_frame();
        fill_frame(ETH_HDR_BYTES - 1, ETH_IPV4, 8'h45, PROTO_TCP, 8'h50, 8'h12);
        send_frame();
        fill_frame(ETH_HDR_BYTES, 16'h1234, 8'h45, PROTO_TCP, 8'h50, 8'h12);
        send_frame();
        wait_drained();
    endtask

    task automatic test_ipv4();
        fill_frame(60, ETH_IPV4, 8'h45, PROTO_TCP, 8'h50, 8'h18);
        send_frame();
        fill_frame(50, ETH_IPV4, 8'h45, PROTO_UDP, 8'h00, 8'h00);
        send_frame();
        // Header ends exactly at the frame end: no transport.
        fill_frame(IPV4_MIN_END, ETH_IPV4, 8'h45, PROTO_TCP, 8'h50, 8'h02);
        send_frame();
        // One byte short of a valid IPv4 header.
        fill_frame(IPV4_MIN_END - 1, ETH_IPV4, 8'h45, PROTO_UDP, 8'h50, 8'h02);
        send_frame();
        // TCP header truncated below its minimum size.
        fill_frame(50, ETH_IPV4, 8'h45, PROTO_TCP, 8'h50, 8'h10);
        send_frame();
        // UDP header exactly fills the frame.
        fill_frame(IPV4_MIN_END + UDP_HDR_BYTES, ETH_IPV4, 8'h45, PROTO_UDP, 8'h00, 8'h00);
        send_frame();
        // IHL below five and a wrong version are both rejected.
        fill_frame(60, ETH_IPV4, 8'h44, PROTO_TCP, 8'h50, 8'h11);
        send_frame();
        fill_frame(60, ETH_IPV4, 8'h55, PROTO_TCP, 8'h50, 8'h11);
        send_frame();
        // Largest IHL and data offset: headers run past the end, payload is zero.
        fill_frame(100, ETH_IPV4, 8'h4F, PROTO_TCP, 8'hFF, 8'hFF);
        send_frame();
        // Data offset below five is taken as given.
        fill_frame(70, ETH_IPV4, 8'h45, PROTO_TCP, 8'h20, 8'h01);
        send_frame();
        // A protocol other than TCP or UDP.
        fill_frame(60, ETH_IPV4, 8'h45, 8'd1, 8'h50, 8'h00);
        send_frame();
        wait_drained();
    endtask

    task automatic test_ipv6();
        fill_frame(90, ETH_IPV6, 8'h60, PROTO_TCP, 8'h80, 8'hA5);
        send_frame();
        fill_frame(70, ETH_IPV6, 8'h6F, PROTO_UDP, 8'h00, 8'h00);
        send_frame();
        // ICMPv6 with bytes past the header, then with none.
        fill_frame(IPV6_END + 6, ETH_IPV6, 8'h60, PROTO_ICMPV6, 8'h00, 8'h00);
        send_frame();
        fill_frame(IPV6_END, ETH_IPV6, 8'h60, PROTO_ICMPV6, 8'h00, 8'h00);
        send_frame();
        fill_frame(80, ETH_IPV6, 8'h45, PROTO_TCP, 8'h50, 8'h02);
        send_frame();
        fill_frame(IPV6_END - 1, ETH_IPV6, 8'h60, PROTO_UDP, 8'h00, 8'h00);
        send_frame();
        wait_drained();
    endtask

    task automatic test_arp_and_unknown();
        fill_frame(42, ETH_ARP, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame();
        fill_frame(60, 16'h88CC, 8'h45, PROTO_TCP, 8'h50, 8'h02);
        send_frame();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int bytes_sent;
        int frames;
        bytes_sent = 0;
        frames     = 0;
        while (bytes_sent < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
            build_random_frame();
            bytes_sent += frame_buf.size();
            send_frame();
            frames++;
            // Let the pipeline empty now and then, so frames also start idle.
            if (frames % 2 == 0) wait_drained();
        end
        wait_drained();
    endtask

    // Back-to-back frames with both sides always ready.
    task automatic test_steady_flow();
        steady_flow = 1'b1;
        repeat (2) begin
            build_random_frame();
            send_frame();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------------

    // The receiver stalls in random bursts until the steady phase begins.
    initial begin
        forever begin
            if (!steady_flow && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    end

    task automatic compare_field(input string name, input int want, input int seen);
        if (want != seen) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, seen);
        end
    endtask

    // Every summary transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin : summary_check
        t_summary seen;
        t_summary want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.malformed = m_axis_tuser[0];
            seen.pclass    = m_axis_tuser[3:1];
            seen.etype     = m_axis_tdata[15:0];
            seen.net       = m_axis_tdata[17:16];
            seen.trn       = m_axis_tdata[19:18];
            seen.proto     = m_axis_tdata[27:20];
            seen.sport     = m_axis_tdata[43:28];
            seen.dport     = m_axis_tdata[59:44];
            seen.flags     = m_axis_tdata[67:60];
            seen.hdr       = m_axis_tdata[81:68];
            seen.payload   = m_axis_tdata[95:82];
            seen.frame     = m_axis_tdata[109:96];
            if (pending_summaries.size() == 0) begin
                mismatches++;
                $display("%0t: summary expected none, actual 0x%0h", $time, seen);
            end else begin
                want = pending_summaries.pop_front();
                compare_field("malformed", want.malformed, seen.malformed);
                compare_field("packet_class", want.pclass, seen.pclass);
                compare_field("ethertype", want.etype, seen.etype);
                compare_field("network_layer", want.net, seen.net);
                compare_field("transport_layer", want.trn, seen.trn);
                compare_field("ip_protocol", want.proto, seen.proto);
                compare_field("source_port", want.sport, seen.sport);
                compare_field("destination_port", want.dport, seen.dport);
                compare_field("tcp_flag_bits", want.flags, seen.flags);
                compare_field("header_bytes", want.hdr, seen.hdr);
                compare_field("payload_bytes", want.payload, seen.payload);
                compare_field("frame_bytes", want.frame, seen.frame);
            end
        end
    end

    // Any transfer on either side counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        frame_state    = '0;
        mismatches     = 0;
        idle_cycles    = 0;
        steady_flow    = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_frames();
        test_ipv4();
        test_ipv6();
        test_arp_and_unknown();
        test_random_traffic();
        test_steady_flow();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/eihp_pkg.sv
rtl/eihp_front.sv
rtl/eihp_queue.sv
rtl/eihp_back.sv
rtl/eth_ip_l4_header_parser_unit.sv
bench/testbench.sv
